>>> design/assert_macros.svh
// Assertion macros used by the RTL of the bucketed member index.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Whenever the trigger holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLIES(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

>>> design/bmi_pkg.sv
// Package of the bucketed member index: sizes, field widths, codes, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmi_pkg;

    localparam int LOCATIONS       = 4;
    localparam int HOST_STATES     = 8;
    localparam int AGE_GROUPS      = 4;
    localparam int BUCKET_CAPACITY = 64;
    localparam int MEMBERS         = 1024;

    localparam int CELLS   = LOCATIONS * HOST_STATES * AGE_GROUPS;
    localparam int LS_N    = LOCATIONS * HOST_STATES;

    // Field widths of the request and the result.
    localparam int MODE_W   = 3;
    localparam int ID_W     = 10;
    localparam int LOC_W    = 2;
    localparam int ST_W     = 3;
    localparam int AGE_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // Internal widths.
    localparam int CELL_W   = LOC_W + ST_W + AGE_W;
    localparam int LS_IDX_W = LOC_W + ST_W;
    localparam int BM_AW    = CELL_W + SLOT_W;
    localparam int CNT_W    = $clog2(BUCKET_CAPACITY + 1);
    localparam int LS_CW    = $clog2(AGE_GROUPS * BUCKET_CAPACITY + 1);
    localparam int LOC_CW   = $clog2(HOST_STATES * AGE_GROUPS * BUCKET_CAPACITY + 1);
    localparam int TOT_W    = $clog2(CELLS * BUCKET_CAPACITY + 1);
    localparam int COUNT_MAX = 2047;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD     = 3'd0,
        MODE_REMOVE  = 3'd1,
        MODE_MOVE    = 3'd2,
        MODE_CELL    = 3'd3,
        MODE_LOCST   = 3'd4,
        MODE_LOC     = 3'd5,
        MODE_TOTAL   = 3'd6,
        MODE_GET     = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    // Clamp a running count to the result field.
    function automatic logic [COUNT_W-1:0] sat_count(input logic [TOT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        if (v > TOT_W'(COUNT_MAX))
            r = COUNT_W'(COUNT_MAX);
        else
            r = v[COUNT_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/bmi_if.sv
// Request and result channel interfaces of the bucketed member index.
// Depends on bmi_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bmi_req_if import bmi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     member_id;
    logic [LOC_W-1:0]    location;
    logic [ST_W-1:0]     host_state;
    logic [AGE_W-1:0]    age_group;
    logic [LOC_W-1:0]    new_location;
    logic [ST_W-1:0]     new_host_state;
    logic [AGE_W-1:0]    new_age_group;
    logic [SLOT_W-1:0]   slot_index;

    modport source (output valid, mode, member_id, location, host_state, age_group,
                    new_location, new_host_state, new_age_group, slot_index,
                    input ready);
    modport sink   (input valid, mode, member_id, location, host_state, age_group,
                    new_location, new_host_state, new_age_group, slot_index,
                    output ready);
endinterface

interface bmi_rsp_if import bmi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [ID_W-1:0]     member_out;
    logic [SLOT_W-1:0]   slot_out;

    modport source (output valid, status, count, member_out, slot_out, input ready);
    modport sink   (input valid, status, count, member_out, slot_out, output ready);
endinterface

`default_nettype wire

>>> design/bucketed_member_index_unit.sv
// Top level of the bucketed member index: sequencer, running counts, memories.
// Depends on bmi_pkg, bmi_if, bmi_ram and assert_macros.svh.
//
//   Channel | Port | Direction | Carries
//   --------+------+-----------+------------------------------------------------
//   request | req  | in        | mode, member_id, source and destination coords,
//           |      |           | slot_index
//   result  | rsp  | out       | status, count, member_out, slot_out
//
// Every request runs from acceptance to a loaded result through RD1 and RD2, two
// reads of the bucket-count memory through its single read port, WR1 and WR2 (take
// out, then append) and DONE, which loads the result register. The request channel
// is ready only while the sequencer is idle, so no request is accepted before the
// last one has loaded its result. A result stays in its output register until
// taken; the sequencer holds its last step while that register is still full.
// Reset clears the sequencer, the running counts and the valid bits of the bucket
// counts at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bucketed_member_index_unit import bmi_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    bmi_req_if.sink   req,
    bmi_rsp_if.source rsp
);

    // One-hot sequencer: the read steps, the two write steps and the result load.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD1  = 6'b000010,
        ST_RD2  = 6'b000100,
        ST_WR1  = 6'b001000,
        ST_WR2  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Fields of the request under work.
    mode_t               mode_reg;
    logic [ID_W-1:0]     id_reg;
    logic [CELL_W-1:0]   src_cell_reg;
    logic [CELL_W-1:0]   dst_cell_reg;
    logic [LS_IDX_W-1:0] src_ls_reg;
    logic [LS_IDX_W-1:0] dst_ls_reg;
    logic [LOC_W-1:0]    src_loc_reg;
    logic [LOC_W-1:0]    dst_loc_reg;
    logic [SLOT_W-1:0]   slot_idx_reg;

    // Values gathered from the memories.
    logic [CNT_W-1:0]    src_cnt_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [ID_W-1:0]     get_member_reg;
    logic [ID_W-1:0]     moved_reg;

    // Decision taken in the second read step.
    logic                take_reg;
    logic                app_reg;
    logic [SLOT_W-1:0]   aslot_reg;
    status_t             status_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [ID_W-1:0]     member_reg;

    // Running counts.
    logic [LS_CW-1:0]    ls_cnt_reg  [LS_N];
    logic [LOC_CW-1:0]   loc_cnt_reg [LOCATIONS];
    logic [TOT_W-1:0]    total_reg;
    logic [CELLS-1:0]    cc_valid_reg;

    // Result register.
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [ID_W-1:0]     out_member_reg;
    logic [SLOT_W-1:0]   out_slot_reg;

    // Memory ports.
    logic                cc_we;
    logic [CELL_W-1:0]   cc_waddr, cc_raddr;
    logic [CNT_W-1:0]    cc_wdata, cc_rdata;
    logic                bm_we;
    logic [BM_AW-1:0]    bm_waddr, bm_raddr;
    logic [ID_W-1:0]     bm_wdata, bm_rdata;
    logic                ms_we;
    logic [ID_W-1:0]     ms_waddr, ms_raddr;
    logic [SLOT_W-1:0]   ms_wdata, ms_rdata;

    logic                accept;
    logic                load_out;
    logic [CNT_W-1:0]    src_cnt_now;
    logic [CNT_W-1:0]    dst_cnt_now;
    logic [CNT_W-1:0]    dst_free;
    logic                same_cell;
    logic                take_now, app_now, stale, full;
    status_t             status_now;
    logic [COUNT_W-1:0]  count_now;
    logic [ID_W-1:0]     member_now;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.count      = out_count_reg;
    assign rsp.member_out = out_member_reg;
    assign rsp.slot_out   = out_slot_reg;

    // A bucket count never written since reset reads as zero.
    assign src_cnt_now = cc_valid_reg[src_cell_reg] ? cc_rdata : '0;
    assign dst_cnt_now = cc_valid_reg[dst_cell_reg] ? cc_rdata : '0;

    // A move inside one bucket frees its own slot before the append.
    assign same_cell = (mode_reg == MODE_MOVE) && (dst_cell_reg == src_cell_reg);
    assign dst_free  = dst_cnt_now - CNT_W'(same_cell);
    assign stale     = {1'b0, slot_reg} >= src_cnt_reg;
    assign full      = dst_free >= CNT_W'(BUCKET_CAPACITY);

    // Read addresses: the source bucket first, then the destination bucket count
    // together with the last member of the source bucket.
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            cc_raddr = {req.location, req.host_state, req.age_group};
            bm_raddr = {req.location, req.host_state, req.age_group, req.slot_index};
        end
        else
        begin
            cc_raddr = dst_cell_reg;
            bm_raddr = {src_cell_reg, SLOT_W'(src_cnt_now - CNT_W'(1))};
        end
        ms_raddr = req.member_id;
    end

    // Outcome of the request, settled in the second read step.
    always_comb
    begin
        take_now   = 1'b0;
        app_now    = 1'b0;
        status_now = STAT_OK;
        count_now  = '0;
        member_now = '0;
        case (mode_reg)
            MODE_ADD:
            begin
                if (full)
                    status_now = STAT_FULL;
                else
                    app_now = 1'b1;
            end
            MODE_REMOVE:
            begin
                if (stale)
                    status_now = STAT_RANGE;
                else
                    take_now = 1'b1;
            end
            MODE_MOVE:
            begin
                if (stale)
                    status_now = STAT_RANGE;
                else if (full)
                    status_now = STAT_FULL;
                else
                begin
                    take_now = 1'b1;
                    app_now  = 1'b1;
                end
            end
            MODE_CELL:   count_now = sat_count(TOT_W'(src_cnt_reg));
            MODE_LOCST:  count_now = sat_count(TOT_W'(ls_cnt_reg[src_ls_reg]));
            MODE_LOC:    count_now = sat_count(TOT_W'(loc_cnt_reg[src_loc_reg]));
            MODE_TOTAL:  count_now = sat_count(total_reg);
            MODE_GET:
            begin
                if ({1'b0, slot_idx_reg} < src_cnt_reg)
                    member_now = get_member_reg;
                else
                    status_now = STAT_RANGE;
            end
            default:     status_now = STAT_RANGE;
        endcase
    end

    // Write ports: the take-out step moves the last member into the freed slot,
    // the append step places the member at the end of its destination bucket.
    always_comb
    begin
        cc_we    = 1'b0;
        bm_we    = 1'b0;
        ms_we    = 1'b0;
        cc_waddr = src_cell_reg;
        cc_wdata = src_cnt_reg - CNT_W'(1);
        bm_waddr = {src_cell_reg, slot_reg};
        bm_wdata = moved_reg;
        ms_waddr = moved_reg;
        ms_wdata = slot_reg;
        if (state_reg == ST_WR1)
        begin
            cc_we = take_reg;
            bm_we = take_reg;
            ms_we = take_reg;
        end
        else if (state_reg == ST_WR2)
        begin
            cc_we    = app_reg;
            bm_we    = app_reg;
            ms_we    = app_reg;
            cc_waddr = dst_cell_reg;
            cc_wdata = CNT_W'(aslot_reg) + CNT_W'(1);
            bm_waddr = {dst_cell_reg, aslot_reg};
            bm_wdata = id_reg;
            ms_waddr = id_reg;
            ms_wdata = aslot_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_WR1;
            ST_WR1:  state_next = ST_WR2;
            ST_WR2:  state_next = ST_DONE;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cc_valid_reg  <= '0;
            total_reg     <= '0;
            for (int i = 0; i < LS_N; i++)
            begin
                ls_cnt_reg[i] <= '0;
            end
            for (int i = 0; i < LOCATIONS; i++)
            begin
                loc_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (cc_we)
                cc_valid_reg[cc_waddr] <= 1'b1;
            if (state_reg == ST_WR1 && take_reg)
            begin
                ls_cnt_reg[src_ls_reg]   <= ls_cnt_reg[src_ls_reg] - LS_CW'(1);
                loc_cnt_reg[src_loc_reg] <= loc_cnt_reg[src_loc_reg] - LOC_CW'(1);
                total_reg                <= total_reg - TOT_W'(1);
            end
            else if (state_reg == ST_WR2 && app_reg)
            begin
                ls_cnt_reg[dst_ls_reg]   <= ls_cnt_reg[dst_ls_reg] + LS_CW'(1);
                loc_cnt_reg[dst_loc_reg] <= loc_cnt_reg[dst_loc_reg] + LOC_CW'(1);
                total_reg                <= total_reg + TOT_W'(1);
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= mode_t'(req.mode);
            id_reg       <= req.member_id;
            src_cell_reg <= {req.location, req.host_state, req.age_group};
            src_ls_reg   <= {req.location, req.host_state};
            src_loc_reg  <= req.location;
            slot_idx_reg <= req.slot_index;
            // An add appends to its own bucket; a move to the destination.
            if (mode_t'(req.mode) == MODE_MOVE)
            begin
                dst_cell_reg <= {req.new_location, req.new_host_state, req.new_age_group};
                dst_ls_reg   <= {req.new_location, req.new_host_state};
                dst_loc_reg  <= req.new_location;
            end
            else
            begin
                dst_cell_reg <= {req.location, req.host_state, req.age_group};
                dst_ls_reg   <= {req.location, req.host_state};
                dst_loc_reg  <= req.location;
            end
        end
        if (state_reg == ST_RD1)
        begin
            src_cnt_reg    <= src_cnt_now;
            slot_reg       <= ms_rdata;
            get_member_reg <= bm_rdata;
        end
        if (state_reg == ST_RD2)
        begin
            moved_reg  <= bm_rdata;
            take_reg   <= take_now;
            app_reg    <= app_now;
            aslot_reg  <= dst_free[SLOT_W-1:0];
            status_reg <= status_now;
            count_reg  <= count_now;
            member_reg <= member_now;
        end
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= count_reg;
            out_member_reg <= member_reg;
            out_slot_reg   <= app_reg ? aslot_reg : '0;
        end
    end

    // Bucket counts, one entry per cell.
    bmi_ram #(.WIDTH(CNT_W), .DEPTH(CELLS)) u_cell_count (
        .clk   (clk),
        .we    (cc_we),
        .waddr (cc_waddr),
        .wdata (cc_wdata),
        .raddr (cc_raddr),
        .rdata (cc_rdata)
    );

    // Bucket contents, one row of slots per cell.
    bmi_ram #(.WIDTH(ID_W), .DEPTH(CELLS * BUCKET_CAPACITY)) u_bucket_members (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // Slot of each member within its bucket.
    bmi_ram #(.WIDTH(SLOT_W), .DEPTH(MEMBERS)) u_member_slot (
        .clk   (clk),
        .we    (ms_we),
        .waddr (ms_waddr),
        .wdata (ms_wdata),
        .raddr (ms_raddr),
        .rdata (ms_rdata)
    );

    `ASSERT_ALWAYS(a_state_onehot, $onehot(state_reg), "sequencer state is not one-hot")
    `ASSERT_IMPLIES(a_write_steps, cc_we || bm_we || ms_we,
        state_reg == ST_WR1 || state_reg == ST_WR2, "memory written outside a write step")
    `ASSERT_IMPLIES(a_take_in_range, state_reg == ST_WR1 && take_reg,
        ({1'b0, slot_reg} < src_cnt_reg) && status_reg == STAT_OK,
        "take-out issued for a stale slot")

endmodule

`default_nettype wire

>>> design/bmi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bmi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> tb/sv/bucketed_member_index_unit_tb.sv
// Self-checking testbench of the bucketed member index: directed table, then random traffic.
// Depends on bmi_pkg, bmi_if and the bucketed_member_index_unit RTL.
`timescale 1ns / 1ps
`default_nettype none

module bucketed_member_index_unit_tb;
    import bmi_pkg::*;

    typedef struct packed {
        mode_t             mode;
        logic [ID_W-1:0]   member_id;
        logic [LOC_W-1:0]  location;
        logic [ST_W-1:0]   host_state;
        logic [AGE_W-1:0]  age_group;
        logic [LOC_W-1:0]  new_location;
        logic [ST_W-1:0]   new_host_state;
        logic [AGE_W-1:0]  new_age_group;
        logic [SLOT_W-1:0] slot_index;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic [ID_W-1:0]    member_out;
        logic [SLOT_W-1:0]  slot_out;
    } result_t;

    // One row of the directed table. When fixed is set, the typed result is
    // expected; otherwise the predictor supplies it.
    typedef struct packed {
        request_t req;
        logic     fixed;
        result_t  res;
    } drow_t;

    localparam int RANDOM_ITEMS = 1425;
    localparam int HOLD_CYCLES  = 300;

    logic clk;
    logic rst_n;

    bmi_req_if req_ch ();
    bmi_rsp_if rsp_ch ();

    bucketed_member_index_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Shadow copy of the index state, updated as each request is accepted.
    int              bucket_fill [CELLS];
    logic [ID_W-1:0] bucket_slots [CELLS][BUCKET_CAPACITY];
    int              slot_of_member [MEMBERS];
    bit              slot_written [MEMBERS];
    int              ls_fill [LS_N];
    int              loc_fill [LOCATIONS];
    int              total_fill;
    int              written_ids [$];

    result_t pending_results [$];
    request_t next_req;
    bit       next_fixed;
    result_t  next_res;
    drow_t    directed [$];

    int errors;
    int phase;          // selects the idle and stall rates
    int hold_left;      // long receiver hold-off, counted down by the receiver
    int sender_pct [4] = '{0, 74, 0, 14};
    int stall_pct  [4] = '{0, 0, 74, 14};

    function automatic int cell_ix(input int l, input int s, input int a);
        return (l * HOST_STATES + s) * AGE_GROUPS + a;
    endfunction

    // Appends a member to the end of its bucket and bumps the running counts.
    function automatic int push_member(input int c, input int id, input int l, input int s);
        int slot;
        slot = bucket_fill[c];
        bucket_slots[c][slot] = ID_W'(id);
        slot_of_member[id] = slot;
        if (!slot_written[id])
            written_ids.insert(written_ids.size(), id);
        slot_written[id] = 1;
        bucket_fill[c] = slot + 1;
        ls_fill[l * HOST_STATES + s]++;
        loc_fill[l]++;
        total_fill++;
        return slot;
    endfunction

    // Swap-and-pop: the last member of the bucket fills the freed slot.
    function automatic void pop_member(input int c, input int slot, input int l, input int s);
        int last;
        logic [ID_W-1:0] moved;
        last = bucket_fill[c] - 1;
        moved = bucket_slots[c][last];
        bucket_slots[c][slot] = moved;
        slot_of_member[moved] = slot;
        bucket_fill[c] = last;
        ls_fill[l * HOST_STATES + s]--;
        loc_fill[l]--;
        total_fill--;
    endfunction

    function automatic logic [COUNT_W-1:0] clamp(input int v);
        return (v > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(v);
    endfunction

    // Computes the result of one request and updates the shadow state. The
    // parameters match the full field ranges, so no coordinate can be out of range.
    function automatic result_t index_result(input request_t q);
        result_t r;
        int src, dst, slot, dst_fill;
        r = '0;
        r.status = STAT_OK;
        src = cell_ix(q.location, q.host_state, q.age_group);
        dst = cell_ix(q.new_location, q.new_host_state, q.new_age_group);
        case (q.mode)
            MODE_ADD:
            begin
                if (bucket_fill[src] >= BUCKET_CAPACITY)
                    r.status = STAT_FULL;
                else
                    r.slot_out = SLOT_W'(push_member(src, q.member_id, q.location,
                                                     q.host_state));
            end
            MODE_REMOVE, MODE_MOVE:
            begin
                slot = slot_of_member[q.member_id];
                if (slot >= bucket_fill[src])
                begin
                    r.status = STAT_RANGE;
                end
                else if (q.mode == MODE_REMOVE)
                begin
                    pop_member(src, slot, q.location, q.host_state);
                end
                else
                begin
                    // A move inside one bucket frees its own slot first.
                    dst_fill = bucket_fill[dst] - ((dst == src) ? 1 : 0);
                    if (dst_fill >= BUCKET_CAPACITY)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        pop_member(src, slot, q.location, q.host_state);
                        r.slot_out = SLOT_W'(push_member(dst, q.member_id, q.new_location,
                                                         q.new_host_state));
                    end
                end
            end
            MODE_CELL:  r.count = clamp(bucket_fill[src]);
            MODE_LOCST: r.count = clamp(ls_fill[q.location * HOST_STATES + q.host_state]);
            MODE_LOC:   r.count = clamp(loc_fill[q.location]);
            MODE_TOTAL: r.count = clamp(total_fill);
            default:
            begin
                if (q.slot_index < bucket_fill[src])
                    r.member_out = bucket_slots[src][q.slot_index];
                else
                    r.status = STAT_RANGE;
            end
        endcase
        return r;
    endfunction

    function automatic request_t mk_req(input mode_t m, input int id, input int l,
                                        input int s, input int a, input int nl,
                                        input int ns, input int na, input int slot);
        request_t q;
        q.mode = m;
        q.member_id = ID_W'(id);
        q.location = LOC_W'(l);
        q.host_state = ST_W'(s);
        q.age_group = AGE_W'(a);
        q.new_location = LOC_W'(nl);
        q.new_host_state = ST_W'(ns);
        q.new_age_group = AGE_W'(na);
        q.slot_index = SLOT_W'(slot);
        return q;
    endfunction

    function automatic result_t mk_res(input status_t st, input int cnt, input int mem,
                                       input int slot);
        result_t r;
        r.status = st;
        r.count = COUNT_W'(cnt);
        r.member_out = ID_W'(mem);
        r.slot_out = SLOT_W'(slot);
        return r;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input request_t q, input bit fixed, input result_t r);
        drow_t row;
        row.req = q;
        row.fixed = fixed;
        row.res = r;
        directed.insert(directed.size(), row);
    endfunction

    // Random coordinates of a bucket. Half of the traffic goes to two hot
    // buckets so that they fill up and the full-bucket case is reached.
    function automatic void pick_cell(output int l, output int s, output int a);
        case ($urandom_range(3))
            0:
            begin
                l = 1;
                s = 2;
                a = 3;
            end
            1:
            begin
                l = 2;
                s = 5;
                a = 0;
            end
            default:
            begin
                l = $urandom_range(LOCATIONS - 1);
                s = $urandom_range(HOST_STATES - 1);
                a = $urandom_range(AGE_GROUPS - 1);
            end
        endcase
    endfunction

    // Builds one random request against the current shadow state. Removes and
    // moves mostly name a member that sits in the bucket given; the rest name
    // a member whose slot was written once but that may have left the bucket.
    function automatic request_t random_request();
        request_t q;
        int l, s, a, nl, ns, na, c, sel, tries, id;
        q = '0;
        q.member_id = ID_W'($urandom);
        q.slot_index = SLOT_W'($urandom);
        sel = $urandom_range(99);
        pick_cell(nl, ns, na);
        q.new_location = LOC_W'(nl);
        q.new_host_state = ST_W'(ns);
        q.new_age_group = AGE_W'(na);
        if (sel < 38)
        begin
            pick_cell(l, s, a);
            q.mode = MODE_ADD;
        end
        else if (sel < 76)
        begin
            q.mode = (sel < 57) ? MODE_REMOVE : MODE_MOVE;
            tries = 0;
            do
            begin
                pick_cell(l, s, a);
                c = cell_ix(l, s, a);
                tries++;
            end
            while (bucket_fill[c] == 0 && tries < 16);
            if (bucket_fill[c] != 0 && $urandom_range(99) < 88)
            begin
                id = bucket_slots[c][$urandom_range(bucket_fill[c] - 1)];
                q.member_id = ID_W'(id);
            end
            else if (written_ids.size() != 0)
            begin
                q.member_id = ID_W'(written_ids[$urandom_range(written_ids.size() - 1)]);
            end
            else
            begin
                q.mode = MODE_ADD;
            end
        end
        else
        begin
            q.mode = mode_t'($urandom_range(MODE_CELL, MODE_GET));
            pick_cell(l, s, a);
            c = cell_ix(l, s, a);
            if (q.mode == MODE_GET && bucket_fill[c] != 0 && $urandom_range(3) != 0)
                q.slot_index = SLOT_W'($urandom_range(bucket_fill[c] - 1));
        end
        q.location = LOC_W'(l);
        q.host_state = ST_W'(s);
        q.age_group = AGE_W'(a);
        return q;
    endfunction

    // Presents one request and returns once it has been accepted. Valid stays
    // high into the next call unless that call inserts idle cycles.
    task automatic offer(input request_t q, input bit fixed, input result_t r);
        @(negedge clk);
        while ($urandom_range(99) < sender_pct[phase])
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        next_req = q;
        next_fixed = fixed;
        next_res = r;
        req_ch.valid = 1'b1;
        {req_ch.mode, req_ch.member_id, req_ch.location, req_ch.host_state,
         req_ch.age_group, req_ch.new_location, req_ch.new_host_state,
         req_ch.new_age_group, req_ch.slot_index} = q;
        forever
        begin
            @(posedge clk);
            if (req_ch.valid && req_ch.ready)
                break;
        end
    endtask

    task automatic field_check(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // Each accepted request is predicted at the edge that accepts it.
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            r = index_result(next_req);
            if (next_fixed)
                r = next_res;
            pending_results.insert(pending_results.size(), r);
        end
    end

    // Each accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                field_check("status", want.status, rsp_ch.status);
                field_check("count", want.count, rsp_ch.count);
                field_check("member_out", want.member_out, rsp_ch.member_out);
                field_check("slot_out", want.slot_out, rsp_ch.slot_out);
            end
        end
    end

    // Result side: random stalls per phase, plus the one long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready = 1'b0;
        end
        else if (hold_left > 0)
        begin
            rsp_ch.ready = 1'b0;
            hold_left--;
        end
        else
        begin
            rsp_ch.ready = ($urandom_range(99) >= stall_pct[phase]);
        end
    end

    initial
    begin
        int k;
        errors = 0;
        phase = 0;
        hold_left = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        {req_ch.mode, req_ch.member_id, req_ch.location, req_ch.host_state,
         req_ch.age_group, req_ch.new_location, req_ch.new_host_state,
         req_ch.new_age_group, req_ch.slot_index} = '0;
        foreach (bucket_fill[i]) bucket_fill[i] = 0;
        foreach (slot_of_member[i]) slot_of_member[i] = 0;
        foreach (slot_written[i]) slot_written[i] = 0;
        foreach (ls_fill[i]) ls_fill[i] = 0;
        foreach (loc_fill[i]) loc_fill[i] = 0;
        total_fill = 0;

        // Directed table: empty index, extreme ids and coordinates, every mode,
        // a move inside one bucket, a get beyond the count and a stale slot.
        add_row(mk_req(MODE_TOTAL, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(STAT_OK, 0, 0, 0));
        add_row(mk_req(MODE_LOC, 0, 3, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(STAT_OK, 0, 0, 0));
        add_row(mk_req(MODE_CELL, 0, 3, 7, 3, 0, 0, 0, 0), 1'b1, mk_res(STAT_OK, 0, 0, 0));
        add_row(mk_req(MODE_GET, 0, 0, 0, 0, 0, 0, 0, 63), 1'b1,
                mk_res(STAT_RANGE, 0, 0, 0));
        add_row(mk_req(MODE_ADD, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(STAT_OK, 0, 0, 0));
        add_row(mk_req(MODE_ADD, 1023, 3, 7, 3, 3, 7, 3, 63), 1'b1,
                mk_res(STAT_OK, 0, 0, 0));
        add_row(mk_req(MODE_ADD, 512, 3, 7, 3, 0, 0, 0, 0), 1'b1, mk_res(STAT_OK, 0, 0, 1));
        add_row(mk_req(MODE_ADD, 341, 3, 7, 3, 2, 5, 1, 42), 1'b1, mk_res(STAT_OK, 0, 0, 2));
        add_row(mk_req(MODE_GET, 0, 3, 7, 3, 0, 0, 0, 1), 1'b1, mk_res(STAT_OK, 0, 512, 0));
        add_row(mk_req(MODE_CELL, 0, 3, 7, 3, 0, 0, 0, 0), 1'b1, mk_res(STAT_OK, 3, 0, 0));
        add_row(mk_req(MODE_LOCST, 0, 3, 7, 0, 0, 0, 0, 0), 1'b1, mk_res(STAT_OK, 3, 0, 0));
        add_row(mk_req(MODE_LOC, 0, 3, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(STAT_OK, 3, 0, 0));
        add_row(mk_req(MODE_TOTAL, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(STAT_OK, 4, 0, 0));
        add_row(mk_req(MODE_REMOVE, 1023, 3, 7, 3, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(MODE_GET, 0, 3, 7, 3, 0, 0, 0, 0), 1'b1, mk_res(STAT_OK, 0, 341, 0));
        add_row(mk_req(MODE_MOVE, 512, 3, 7, 3, 0, 0, 0, 0), 1'b1, mk_res(STAT_OK, 0, 0, 1));
        add_row(mk_req(MODE_MOVE, 341, 3, 7, 3, 3, 7, 3, 0), 1'b0, '0);
        add_row(mk_req(MODE_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(MODE_REMOVE, 1023, 1, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_res(STAT_RANGE, 0, 0, 0));
        add_row(mk_req(MODE_MOVE, 0, 3, 7, 3, 1, 2, 3, 0), 1'b0, '0);
        add_row(mk_req(MODE_TOTAL, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(MODE_GET, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (k = 0; k < directed.size(); k++)
            offer(directed[k].req, directed[k].fixed, directed[k].res);

        // Random traffic in four idling phases. Early in the first phase the
        // receiver holds off long enough that the block backs up and drops ready.
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            phase = (k * 4) / RANDOM_ITEMS;
            if (k == 40)
                hold_left = HOLD_CYCLES;
            offer(random_request(), 1'b0, '0);
        end
        @(negedge clk);
        req_ch.valid = 1'b0;

        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
